/* rtl/mgc_pkg.sv */
// Shared types, constants and the clip helper for the Meyer capacitance core.
// Used by mgc_div and meyer_capacitance_with_derivatives_core.
`default_nettype none

package mgc_pkg;

    localparam int VOLT_FRAC_BITS = 24;

    // pipelined divider: dividend, divisor and quotient widths, register stage count
    localparam int DIV_DW  = 97;
    localparam int DIV_VW  = 66;
    localparam int DIV_QW  = 63;
    localparam int DIV_LAT = DIV_QW + 1;

    localparam logic [2:0] REGION_ACCUM = 3'd0;
    localparam logic [2:0] REGION_DEPL  = 3'd1;
    localparam logic [2:0] REGION_WEAK  = 3'd2;
    localparam logic [2:0] REGION_SAT   = 3'd3;
    localparam logic [2:0] REGION_LIN   = 3'd4;

    localparam logic CFG_PHI = 1'b0;
    localparam logic CFG_COX = 1'b1;

    localparam logic [30:0] PHI_RESET = 31'd10066330;
    localparam logic [30:0] COX_RESET = 31'd65536;

    typedef struct packed {
        logic signed [31:0] gate_source_voltage;
        logic signed [31:0] gate_drain_voltage;
        logic signed [31:0] threshold_voltage;
        logic signed [31:0] saturation_voltage;
    } bias_t;

    typedef struct packed {
        logic signed [31:0] cap_gate_source;
        logic signed [31:0] cap_gate_drain;
        logic signed [31:0] cap_gate_bulk;
        logic signed [31:0] dgs_by_dvgs;
        logic signed [31:0] cross_derivative;
        logic signed [31:0] dgd_by_dvgd;
        logic signed [31:0] dgb_by_dvgs;
        logic [2:0]         region;
        logic               saturated;
    } caps_t;

    // bit 32: clipped, bits 31:0: signed field from sign and magnitude
    function automatic logic [32:0] fit32(input logic neg, input logic big,
                                          input logic [DIV_QW-1:0] q);
        logic [32:0] r;
        if (neg) begin
            if (big || q > DIV_QW'(33'h080000000)) r = {1'b1, 32'h80000000};
            else                                   r = {1'b0, 32'(-q)};
        end else begin
            if (big || q > DIV_QW'(33'h07FFFFFFF)) r = {1'b1, 32'h7FFFFFFF};
            else                                   r = {1'b0, q[31:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/mgc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on mgc_pkg for widths and stage count.
`default_nettype none

module mgc_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [mgc_pkg::DIV_DW-1:0]  dividend,
    input  logic [mgc_pkg::DIV_VW-1:0]  divisor,
    output logic [mgc_pkg::DIV_QW-1:0]  quotient,
    output logic                        big
);
    import mgc_pkg::*;

    logic [DIV_VW-1:0] rem_reg [DIV_LAT];
    logic [DIV_QW-1:0] lq_reg  [DIV_LAT];
    logic [DIV_VW-1:0] dvs_reg [DIV_LAT];
    logic              big_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DIV_VW'(dividend[DIV_DW-1:DIV_QW]);
            lq_reg[0]  <= dividend[DIV_QW-1:0];
            dvs_reg[0] <= divisor;
            big_reg[0] <= (divisor == '0) ||
                          (DIV_VW'(dividend[DIV_DW-1:DIV_QW]) >= divisor);
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_step
        logic [DIV_VW:0] trial;
        logic            take;
        assign trial = {rem_reg[k-1], lq_reg[k-1][DIV_QW-1]};
        assign take  = trial >= {1'b0, dvs_reg[k-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? DIV_VW'(trial - {1'b0, dvs_reg[k-1]}) : DIV_VW'(trial);
                lq_reg[k]  <= {lq_reg[k-1][DIV_QW-2:0], take};
                dvs_reg[k] <= dvs_reg[k-1];
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign quotient = lq_reg[DIV_LAT-1];
    assign big      = big_reg[DIV_LAT-1];

endmodule

`default_nettype wire

/* rtl/meyer_capacitance_with_derivatives_core.sv */
// Top level of the Meyer gate capacitance core with voltage derivatives.
// Depends on mgc_pkg and mgc_div.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one bias point per beat.
//   out channel (out_valid/out_ready/out_data): one result beat per bias point,
//   in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes phi,
//   index 1 writes cox; always ready; write only while the core is empty.
// Throughput: one beat per cycle, sustained while the output is not stalled.
// Depth: two banks of 64-stage dividers set the pipeline depth from input
//   accept to output valid: the linear-region derivatives need a quotient that
//   feeds a second quotient.
// Stall: when out_ready is low with a result held, the pipeline keeps moving
//   while its last stage is empty and freezes once it is not; nothing is lost
//   or repeated. in_ready follows that freeze.
// Reset: clears all valid bits and loads the default phi and cox.
`default_nettype none

module meyer_capacitance_with_derivatives_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mgc_pkg::bias_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mgc_pkg::caps_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [30:0]    cfg_data
);
    import mgc_pkg::*;

    localparam int NV = 7 + 2 * DIV_LAT;

    typedef struct packed {
        logic [2:0]  region;
        logic        neg_gd;
        logic        neg_gs;
        logic        nneg;
        logic        xneg;
        logic [1:0]  s_der;
        logic [33:0] n3;
        logic [31:0] acc_gb;
        logic [31:0] sat_gs;
    } side_t;

    typedef struct packed {
        caps_t       res;
        logic        nneg;
        logic        xneg;
        logic [2:0]  big1;
    } leaf_t;

    logic [30:0] phi_reg, cox_reg;
    logic        en;
    logic [NV-1:0] vld_reg;
    caps_t       out_reg;
    logic        out_valid_reg;

    // stage 1
    logic signed [32:0] s1_vgst_reg, s1_vds_reg, s1_vgdt_reg;
    logic signed [31:0] s1_vdsat_reg;
    // stage 2
    logic [2:0]         s2_region_reg;
    logic signed [31:0] s2_vdsat_reg;
    logic signed [33:0] s2_e_reg, s2_n_reg;
    logic signed [34:0] s2_d_reg;
    logic signed [32:0] s2_vgst_reg, s2_vgdt_reg;
    logic [31:0]        s2_w_reg;
    // stage 3
    logic [2:0]  s3_region_reg;
    logic [31:0] s3_a_reg, s3_e_reg, s3_d_reg, s3_g_reg, s3_h_reg, s3_n_reg;
    logic [1:0]  s3_sder_reg;
    logic [31:0] s3_vgm_reg, s3_w_reg;
    logic        s3_nneg_reg, s3_xneg_reg;
    // stage 4
    logic [2:0]  s4_region_reg;
    logic [63:0] s4_aa_reg, s4_dd_reg, s4_ee_reg, s4_gg_reg, s4_gh_reg, s4_hh_reg, s4_nn_reg;
    logic [1:0]  s4_sder_reg;
    logic [31:0] s4_n_reg, s4_vgm_reg, s4_w_reg;
    logic        s4_nneg_reg, s4_xneg_reg;
    // stages 5 to 7
    logic [63:0]       s5_x_reg   [5];
    logic [DIV_VW-1:0] s5_dvs_reg [5];
    side_t             s5_side_reg;
    logic [62:0]       s6_lo_reg  [5];
    logic [62:0]       s6_hi_reg  [5];
    logic [DIV_VW-1:0] s6_dvs_reg [5];
    side_t             s6_side_reg;
    logic [DIV_DW-1:0] s7_dvd_reg [5];
    logic [DIV_VW-1:0] s7_dvs_reg [5];
    side_t             s7_side_reg;

    side_t             d1_side_reg [DIV_LAT];
    leaf_t             d2_side_reg [DIV_LAT];

    logic [DIV_QW-1:0] q1 [5];
    logic              b1 [5];
    logic [DIV_QW-1:0] q2 [3];
    logic              b2 [3];
    logic [DIV_DW-1:0] b2_dvd [3];
    logic [DIV_VW-1:0] b2_dvs;
    leaf_t             leaf;
    caps_t             fin;

    // stage-2 combinational
    logic signed [34:0] phi_s, vgst35;
    logic signed [33:0] e34;
    logic               c_acc, c_depl, c_weak, c_sat;
    // stage-3 combinational
    logic signed [34:0] x_vdsat, x_e, x_d, x_vgdt, x_n, x_vgst;
    logic [34:0]        am, em, dm, gm, nm, or_cap;
    logic [1:0]         s_cap, s_der;
    logic [33:0]        or_der;
    // stage-5 combinational
    logic               lin5, ngd, ngs;
    logic [65:0]        d2x3;
    logic [62:0]        cox_third;
    logic [32:0]        phi2, phi3;

    assign en        = !vld_reg[NV-1] || out_ready || !out_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phi_reg       <= PHI_RESET;
            cox_reg       <= COX_RESET;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PHI: phi_reg <= cfg_data;
                    CFG_COX: cox_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (en)
                vld_reg <= {vld_reg[NV-2:0], in_valid};
            if (out_ready || !out_valid_reg)
                out_valid_reg <= vld_reg[NV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
            out_reg <= fin;
    end

    // region and differences
    assign phi_s  = {4'b0, phi_reg};
    assign vgst35 = 35'(s1_vgst_reg);
    assign e34    = 34'(s1_vdsat_reg) - 34'(s1_vds_reg);
    assign c_acc  = vgst35 <= -phi_s;
    assign c_depl = (vgst35 <<< 1) <= -phi_s;
    assign c_weak = vgst35 <= 35'sd0;
    assign c_sat  = 35'(s1_vdsat_reg) <= 35'(s1_vds_reg);

    // magnitudes and shared normalizing shifts
    assign x_vdsat = 35'(s2_vdsat_reg);
    assign x_e     = 35'(s2_e_reg);
    assign x_d     = s2_d_reg;
    assign x_vgdt  = 35'(s2_vgdt_reg);
    assign x_n     = 35'(s2_n_reg);
    assign x_vgst  = 35'(s2_vgst_reg);
    assign am      = x_vdsat[34] ? 35'(-x_vdsat) : 35'(x_vdsat);
    assign em      = 35'(x_e);
    assign dm      = x_d[34] ? 35'(-x_d) : 35'(x_d);
    assign gm      = x_vgdt[34] ? 35'(-x_vgdt) : 35'(x_vgdt);
    assign nm      = x_n[34] ? 35'(-x_n) : 35'(x_n);
    assign or_cap  = am | em | dm;
    assign s_cap   = or_cap[34] ? 2'd3 : or_cap[33] ? 2'd2 : or_cap[32] ? 2'd1 : 2'd0;
    assign or_der  = gm[33:0] | 34'(x_vgst) | nm[33:0];
    assign s_der   = or_der[33] ? 2'd2 : or_der[32] ? 2'd1 : 2'd0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_vgst_reg  <= 33'(in_data.gate_source_voltage) - 33'(in_data.threshold_voltage);
            s1_vds_reg   <= 33'(in_data.gate_source_voltage) - 33'(in_data.gate_drain_voltage);
            s1_vgdt_reg  <= 33'(in_data.gate_drain_voltage) - 33'(in_data.threshold_voltage);
            s1_vdsat_reg <= in_data.saturation_voltage;

            if (c_acc)       s2_region_reg <= REGION_ACCUM;
            else if (c_depl) s2_region_reg <= REGION_DEPL;
            else if (c_weak) s2_region_reg <= REGION_WEAK;
            else if (c_sat)  s2_region_reg <= REGION_SAT;
            else             s2_region_reg <= REGION_LIN;
            s2_vdsat_reg <= s1_vdsat_reg;
            s2_e_reg     <= e34;
            s2_d_reg     <= 35'(s1_vdsat_reg) + 35'(e34);
            s2_n_reg     <= 34'(s1_vgst_reg) + 34'(s1_vgdt_reg);
            s2_vgst_reg  <= s1_vgst_reg;
            s2_vgdt_reg  <= s1_vgdt_reg;
            s2_w_reg     <= 32'((vgst35 <<< 1) + phi_s);

            s3_region_reg <= s2_region_reg;
            s3_a_reg      <= 32'(am >> s_cap);
            s3_e_reg      <= 32'(em >> s_cap);
            s3_d_reg      <= 32'(dm >> s_cap);
            s3_g_reg      <= 32'(gm >> s_der);
            s3_h_reg      <= 32'(x_vgst >> s_der);
            s3_n_reg      <= 32'(nm >> s_der);
            s3_sder_reg   <= s_der;
            s3_vgm_reg    <= 32'(-x_vgst);
            s3_w_reg      <= s2_w_reg;
            s3_nneg_reg   <= x_n[34];
            s3_xneg_reg   <= (!x_vgdt[34]) != x_n[34];

            s4_region_reg <= s3_region_reg;
            s4_aa_reg     <= 64'(s3_a_reg) * 64'(s3_a_reg);
            s4_dd_reg     <= 64'(s3_d_reg) * 64'(s3_d_reg);
            s4_ee_reg     <= 64'(s3_e_reg) * 64'(s3_e_reg);
            s4_gg_reg     <= 64'(s3_g_reg) * 64'(s3_g_reg);
            s4_gh_reg     <= 64'(s3_h_reg) * 64'(s3_g_reg);
            s4_hh_reg     <= 64'(s3_h_reg) * 64'(s3_h_reg);
            s4_nn_reg     <= 64'(s3_n_reg) * 64'(s3_n_reg);
            s4_sder_reg   <= s3_sder_reg;
            s4_n_reg      <= s3_n_reg;
            s4_vgm_reg    <= s3_vgm_reg;
            s4_w_reg      <= s3_w_reg;
            s4_nneg_reg   <= s3_nneg_reg;
            s4_xneg_reg   <= s3_xneg_reg;
        end
    end

    // slot operands per region
    assign lin5      = s4_region_reg == REGION_LIN;
    assign ngd       = s4_aa_reg > s4_dd_reg;
    assign ngs       = s4_ee_reg > s4_dd_reg;
    assign d2x3      = 66'(s4_dd_reg) + (66'(s4_dd_reg) << 1);
    assign cox_third = 63'(cox_reg) * 63'(32'hAAAAAAAB);
    assign phi2      = {1'b0, phi_reg, 1'b0};
    assign phi3      = phi2 + 33'(phi_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (lin5)
            begin
                s5_x_reg[0]   <= ngd ? s4_aa_reg - s4_dd_reg : s4_dd_reg - s4_aa_reg;
                s5_x_reg[1]   <= ngs ? s4_ee_reg - s4_dd_reg : s4_dd_reg - s4_ee_reg;
                s5_x_reg[2]   <= s4_gg_reg;
                s5_x_reg[3]   <= s4_gh_reg;
                s5_x_reg[4]   <= s4_hh_reg;
                s5_dvs_reg[0] <= d2x3;
                s5_dvs_reg[1] <= d2x3;
                s5_dvs_reg[2] <= 66'(s4_nn_reg);
                s5_dvs_reg[3] <= 66'(s4_nn_reg);
                s5_dvs_reg[4] <= 66'(s4_nn_reg);
            end
            else
            begin
                s5_x_reg[0]   <= 64'(s4_vgm_reg);
                s5_x_reg[1]   <= 64'(1) << VOLT_FRAC_BITS;
                s5_x_reg[2]   <= 64'(s4_w_reg);
                s5_x_reg[3]   <= 64'(1) << (VOLT_FRAC_BITS + 1);
                s5_x_reg[4]   <= '0;
                s5_dvs_reg[0] <= 66'(phi2);
                s5_dvs_reg[1] <= 66'(phi2);
                s5_dvs_reg[2] <= 66'(phi3);
                s5_dvs_reg[3] <= 66'(phi3);
                s5_dvs_reg[4] <= 66'(phi3);
            end
            s5_side_reg.region <= s4_region_reg;
            s5_side_reg.neg_gd <= ngd;
            s5_side_reg.neg_gs <= ngs;
            s5_side_reg.nneg   <= s4_nneg_reg;
            s5_side_reg.xneg   <= s4_xneg_reg;
            s5_side_reg.s_der  <= s4_sder_reg;
            s5_side_reg.n3     <= 34'(s4_n_reg) + (34'(s4_n_reg) << 1);
            s5_side_reg.acc_gb <= 32'(cox_reg >> 1);
            s5_side_reg.sat_gs <= 32'(cox_third >> 33);

            for (int k = 0; k < 5; k++)
            begin
                s6_lo_reg[k]  <= 63'(cox_reg) * 63'(s5_x_reg[k][31:0]);
                s6_hi_reg[k]  <= 63'(cox_reg) * 63'(s5_x_reg[k][63:32]);
                s6_dvs_reg[k] <= s5_dvs_reg[k];

                if (s6_side_reg.region == REGION_LIN && k >= 2)
                    s7_dvd_reg[k] <= (DIV_DW'(s6_hi_reg[k]) << 34) + (DIV_DW'(s6_lo_reg[k]) << 2);
                else
                    s7_dvd_reg[k] <= (DIV_DW'(s6_hi_reg[k]) << 32) + DIV_DW'(s6_lo_reg[k]);
                s7_dvs_reg[k] <= s6_dvs_reg[k];
            end
            s6_side_reg <= s5_side_reg;
            s7_side_reg <= s6_side_reg;

            d1_side_reg[0] <= s7_side_reg;
            d2_side_reg[0] <= leaf;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                d1_side_reg[k] <= d1_side_reg[k-1];
                d2_side_reg[k] <= d2_side_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < 5; k++)
    begin : g_bank1
        mgc_div u_div (
            .clk      (clk),
            .en       (en),
            .dividend (s7_dvd_reg[k]),
            .divisor  (s7_dvs_reg[k]),
            .quotient (q1[k]),
            .big      (b1[k])
        );
    end

    assign b2_dvs = DIV_VW'(d1_side_reg[DIV_LAT-1].n3);

    for (genvar k = 0; k < 3; k++)
    begin : g_bank2
        assign b2_dvd[k] = DIV_DW'(q1[k+2])
                           << (5'(VOLT_FRAC_BITS) - 5'(d1_side_reg[DIV_LAT-1].s_der));
        mgc_div u_div (
            .clk      (clk),
            .en       (en),
            .dividend (b2_dvd[k]),
            .divisor  (b2_dvs),
            .quotient (q2[k]),
            .big      (b2[k])
        );
    end

    // capacitances and depletion- and weak-region slopes after the first divider bank
    always_comb
    begin
        side_t       sd;
        logic [32:0] f0, f1, f2, f3;
        sd = d1_side_reg[DIV_LAT-1];
        leaf = '0;
        leaf.res.region = sd.region;
        leaf.nneg = sd.nneg;
        leaf.xneg = sd.xneg;
        leaf.big1 = {b1[4], b1[3], b1[2]};
        f0 = fit32(1'b0, b1[0], q1[0]);
        f1 = fit32(1'b1, b1[1], q1[1]);
        f2 = fit32(1'b0, b1[2], q1[2]);
        f3 = fit32(1'b0, b1[3], q1[3]);
        case (sd.region)
            REGION_ACCUM:
            begin
                leaf.res.cap_gate_bulk = sd.acc_gb;
            end
            REGION_DEPL:
            begin
                leaf.res.cap_gate_bulk = f0[31:0];
                leaf.res.dgb_by_dvgs   = f1[31:0];
                leaf.res.saturated     = f0[32] | f1[32];
            end
            REGION_WEAK:
            begin
                leaf.res.cap_gate_bulk   = f0[31:0];
                leaf.res.dgb_by_dvgs     = f1[31:0];
                leaf.res.cap_gate_source = f2[31:0];
                leaf.res.dgs_by_dvgs     = f3[31:0];
                leaf.res.saturated       = f0[32] | f1[32] | f2[32] | f3[32];
            end
            REGION_SAT:
            begin
                leaf.res.cap_gate_source = sd.sat_gs;
            end
            default:
            begin
                f0 = fit32(sd.neg_gd, b1[0], q1[0]);
                f1 = fit32(sd.neg_gs, b1[1], q1[1]);
                leaf.res.cap_gate_drain  = f0[31:0];
                leaf.res.cap_gate_source = f1[31:0];
                leaf.res.saturated       = f0[32] | f1[32];
            end
        endcase
    end

    // linear-region derivatives after the second bank
    always_comb
    begin
        leaf_t       ls;
        logic [32:0] g0, g1, g2;
        ls  = d2_side_reg[DIV_LAT-1];
        fin = ls.res;
        g0  = fit32(ls.nneg, ls.big1[0] | b2[0], q2[0]);
        g1  = fit32(ls.xneg, ls.big1[1] | b2[1], q2[1]);
        g2  = fit32(ls.nneg, ls.big1[2] | b2[2], q2[2]);
        if (ls.res.region == REGION_LIN)
        begin
            fin.dgs_by_dvgs      = g0[31:0];
            fin.cross_derivative = g1[31:0];
            fin.dgd_by_dvgd      = g2[31:0];
            fin.saturated        = ls.res.saturated | g0[32] | g1[32] | g2[32];
        end
    end

    a_accum_only_bulk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.region == REGION_ACCUM |->
            out_data.cap_gate_source == 0 && out_data.cap_gate_drain == 0 &&
            out_data.dgb_by_dvgs == 0 && !out_data.saturated)
        else $error("accumulation result carries more than gate-bulk cap");

    a_sat_region_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.region == REGION_SAT |->
            out_data.cap_gate_drain == 0 && out_data.dgs_by_dvgs == 0 &&
            out_data.cross_derivative == 0 && !out_data.saturated)
        else $error("saturated-region result has stray fields");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && vld_reg[NV-1] |-> !in_ready)
        else $error("input taken while full pipeline is stalled");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking bench for the Meyer gate capacitance core: directed bias points, then
// random ones over several phi/cox settings, each result checked against a local model or a fixed expected value.
// Depends on mgc_pkg and meyer_capacitance_with_derivatives_core.
`timescale 1ns / 100ps

module tb;

    import mgc_pkg::*;

    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          DRAIN_CYCLES = 160;
    localparam logic [63:0] BIG63 = 64'h7FFFFFFFFFFFFFFF;

    typedef struct {
        bias_t bias;
        bit    typed;
        caps_t want;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    bias_t in_data = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    caps_t out_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic  cfg_index = CFG_PHI;
    logic  [30:0] cfg_data = '0;

    logic [30:0] phi_now = PHI_RESET;
    logic [30:0] cox_now = COX_RESET;
    caps_t       pending_caps[$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 1'b0;
    int          ready_left = 0;

    meyer_capacitance_with_derivatives_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] c, inout logic sat);
        logic [127:0] q;
        if (c == 0)
        begin
            sat = 1'b1;
            return BIG63;
        end
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        if (q[127:63] != 0)
        begin
            sat = 1'b1;
            return BIG63;
        end
        return q[63:0];
    endfunction

    function automatic logic [31:0] clip32(input logic neg, input logic [63:0] m,
                                           inout logic sat);
        if (neg)
        begin
            if (m > 64'h80000000)
            begin
                sat = 1'b1;
                m = 64'h80000000;
            end
            return 32'(64'h100000000 - m);
        end
        if (m > 64'h7FFFFFFF)
        begin
            sat = 1'b1;
            m = 64'h7FFFFFFF;
        end
        return m[31:0];
    endfunction

    function automatic int fit_shift(input logic [63:0] x, input logic [63:0] y,
                                     input logic [63:0] z);
        logic [63:0] m;
        int s;
        m = x;
        s = 0;
        if (y > m) m = y;
        if (z > m) m = z;
        while ((m >> 32) != 0)
        begin
            m = m >> 1;
            s++;
        end
        return s;
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] linear_cap(input logic [63:0] a, input logic [63:0] d,
                                               input logic [63:0] cox, inout logic sat);
        logic [63:0] a2, d2, diff, v;
        logic        neg;
        a2 = a * a;
        d2 = d * d;
        neg = a2 > d2;
        diff = neg ? a2 - d2 : d2 - a2;
        v = scaled_quot(cox, diff, d2, sat) / 3;
        return clip32(neg, v, sat);
    endfunction

    function automatic logic [31:0] linear_slope(input logic [63:0] x, input logic [63:0] y,
                                                 input logic [63:0] n, input int s,
                                                 input logic neg, input logic [63:0] cox,
                                                 inout logic sat);
        logic [63:0] part, v;
        part = scaled_quot(x * y, 4 * cox, n * n, sat);
        v = scaled_quot(part, 64'd1 << (VOLT_FRAC_BITS - s), 3 * n, sat);
        return clip32(neg, v, sat);
    endfunction

    function automatic caps_t meyer_caps(input bias_t b, input logic [30:0] phi_r,
                                         input logic [30:0] cox_r);
        longint      vgs, vgd, von, vdsat, vgst, vds, p, e, d, vgdt, n;
        logic [63:0] cox, phi, am, em, dm, g, h, nm;
        int          s;
        logic        sat;
        caps_t       r;
        vgs = longint'(b.gate_source_voltage);
        vgd = longint'(b.gate_drain_voltage);
        von = longint'(b.threshold_voltage);
        vdsat = longint'(b.saturation_voltage);
        vgst = vgs - von;
        vds = vgs - vgd;
        p = longint'({33'd0, phi_r});
        cox = {33'd0, cox_r};
        phi = {33'd0, phi_r};
        sat = 1'b0;
        r = '0;
        if (vgst <= -p)
        begin
            r.region = REGION_ACCUM;
            r.cap_gate_bulk = clip32(1'b0, cox / 2, sat);
        end
        else if (2 * vgst <= -p || vgst <= 0)
        begin
            r.region = (2 * vgst <= -p) ? REGION_DEPL : REGION_WEAK;
            r.cap_gate_bulk = clip32(1'b0, scaled_quot(mag(vgst), cox, 2 * phi, sat), sat);
            r.dgb_by_dvgs = clip32(1'b1,
                scaled_quot(cox, 64'd1 << VOLT_FRAC_BITS, 2 * phi, sat), sat);
            if (r.region == REGION_WEAK)
            begin
                r.cap_gate_source = clip32(1'b0,
                    scaled_quot(cox, 64'(2 * vgst + p), 3 * phi, sat), sat);
                r.dgs_by_dvgs = clip32(1'b0,
                    scaled_quot(cox, 64'd1 << (VOLT_FRAC_BITS + 1), 3 * phi, sat), sat);
            end
        end
        else if (vdsat <= vds)
        begin
            r.region = REGION_SAT;
            r.cap_gate_source = clip32(1'b0, cox / 3, sat);
        end
        else
        begin
            e = vdsat - vds;
            d = vdsat + e;
            vgdt = vgd - von;
            n = vgst + vgdt;
            am = mag(vdsat);
            em = 64'(e);
            dm = mag(d);
            g = mag(vgdt);
            h = 64'(vgst);
            nm = mag(n);
            r.region = REGION_LIN;
            s = fit_shift(am, em, dm);
            r.cap_gate_drain = linear_cap(am >> s, dm >> s, cox, sat);
            r.cap_gate_source = linear_cap(em >> s, dm >> s, cox, sat);
            s = fit_shift(g, h, nm);
            g = g >> s;
            h = h >> s;
            nm = nm >> s;
            r.dgs_by_dvgs = linear_slope(g, g, nm, s, n < 0, cox, sat);
            r.cross_derivative = linear_slope(h, g, nm, s, (vgdt >= 0) != (n < 0), cox, sat);
            r.dgd_by_dvgd = linear_slope(h, h, nm, s, n < 0, cox, sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 100);
    endfunction

    function automatic int spread_volt();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic bias_t random_bias(input logic [30:0] phi_r);
        bias_t b;
        int    von, vgst, vds;
        int    m;
        m = $urandom_range(0, 9);
        if (m < 2)
        begin
            b = {$urandom, $urandom, $urandom, $urandom};
            return b;
        end
        von = spread_volt();
        case ($urandom_range(0, 4))
            0: vgst = -int'(phi_r) - $urandom_range(0, 3) + $urandom_range(0, 3);
            1: vgst = -int'(phi_r / 2) - $urandom_range(0, 3) + $urandom_range(0, 3);
            2: vgst = -int'($urandom_range(0, phi_r));
            default: vgst = spread_volt() & 32'h7FFFFFFF;
        endcase
        vds = spread_volt();
        b.threshold_voltage = von;
        b.gate_source_voltage = von + vgst;
        b.gate_drain_voltage = b.gate_source_voltage - vds;
        if ($urandom_range(0, 3) == 0)
            b.saturation_voltage = vds + $urandom_range(0, 2) - 1;
        else
            b.saturation_voltage = vds + (spread_volt() & 32'h7FFFFFFF);
        if ($urandom_range(0, 7) == 0)
            b.saturation_voltage = spread_volt();
        return b;
    endfunction

    task automatic send_bias(input bias_t b, input bit typed, input caps_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge clk); while (!in_ready);
        pending_caps.push_back(typed ? want : meyer_caps(b, phi_now, cox_now));
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_PHI) phi_now = value;
        else cox_now = value;
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending_caps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        int r;
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 60)
            begin
                out_ready <= 1'b1;
                ready_left <= $urandom_range(0, 20);
            end
            else if (r < 95)
            begin
                out_ready <= 1'b0;
                ready_left <= $urandom_range(0, 4);
            end
            else
            begin
                out_ready <= 1'b0;
                ready_left <= $urandom_range(20, 150);
            end
        end
    end

    always @(posedge clk)
    begin
        caps_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_caps.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                want = pending_caps.pop_front();
                if (out_data.cap_gate_source !== want.cap_gate_source)
                begin
                    $error("cap_gate_source exp %h got %h",
                           want.cap_gate_source, out_data.cap_gate_source);
                    errors++;
                end
                if (out_data.cap_gate_drain !== want.cap_gate_drain)
                begin
                    $error("cap_gate_drain exp %h got %h",
                           want.cap_gate_drain, out_data.cap_gate_drain);
                    errors++;
                end
                if (out_data.cap_gate_bulk !== want.cap_gate_bulk)
                begin
                    $error("cap_gate_bulk exp %h got %h",
                           want.cap_gate_bulk, out_data.cap_gate_bulk);
                    errors++;
                end
                if (out_data.dgs_by_dvgs !== want.dgs_by_dvgs)
                begin
                    $error("dgs_by_dvgs exp %h got %h",
                           want.dgs_by_dvgs, out_data.dgs_by_dvgs);
                    errors++;
                end
                if (out_data.cross_derivative !== want.cross_derivative)
                begin
                    $error("cross_derivative exp %h got %h",
                           want.cross_derivative, out_data.cross_derivative);
                    errors++;
                end
                if (out_data.dgd_by_dvgd !== want.dgd_by_dvgd)
                begin
                    $error("dgd_by_dvgd exp %h got %h",
                           want.dgd_by_dvgd, out_data.dgd_by_dvgd);
                    errors++;
                end
                if (out_data.dgb_by_dvgs !== want.dgb_by_dvgs)
                begin
                    $error("dgb_by_dvgs exp %h got %h",
                           want.dgb_by_dvgs, out_data.dgb_by_dvgs);
                    errors++;
                end
                if (out_data.region !== want.region)
                begin
                    $error("region exp %0d got %0d", want.region, out_data.region);
                    errors++;
                end
                if (out_data.saturated !== want.saturated)
                begin
                    $error("saturated exp %0d got %0d", want.saturated, out_data.saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t   rows[14];
        logic [30:0] phi_set[7];
        logic [30:0] cox_set[7];
        int          k;
        int          j;
        rows[0]  = '{'{32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h0}, 1'b1,
                     '{0, 0, 32768, 0, 0, 0, 0, REGION_ACCUM, 1'b0}};
        rows[1]  = '{'{32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h80000000}, 1'b1,
                     '{21845, 0, 0, 0, 0, 0, 0, REGION_SAT, 1'b0}};
        rows[2]  = '{'{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
        rows[3]  = '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, '0};
        rows[4]  = '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, '0};
        rows[5]  = '{'{-32'sd7549747, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
        rows[6]  = '{'{-32'sd2000000, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
        rows[7]  = '{'{-32'sd10066330, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
        rows[8]  = '{'{-32'sd5033165, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
        rows[9]  = '{'{32'h02000000, 32'h01800000, 32'h00800000, 32'h01000000}, 1'b0, '0};
        rows[10] = '{'{32'sd10, 32'sd12, 32'h0, -32'sd1}, 1'b0, '0};
        rows[11] = '{'{32'sd5, -32'sd5, 32'h0, 32'sd20}, 1'b0, '0};
        rows[12] = '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1}, 1'b0, '0};
        rows[13] = '{'{32'h01000000, 32'h0, 32'h0, 32'h01000000}, 1'b0, '0};
        phi_set = '{PHI_RESET, 31'd1, 31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF, 31'd0, 31'd0};
        cox_set = '{COX_RESET, 31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd1, 31'd0, 31'd0};
        phi_set[5] = 31'($urandom_range(1, 31'h7FFFFFFF));
        phi_set[6] = 31'($urandom_range(1000, 50000000));
        cox_set[5] = 31'($urandom);
        cox_set[6] = 31'($urandom_range(1, 1 << 20));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_bias(rows[i].bias, rows[i].typed, rows[i].want);

        for (k = 0; k < 7; k++)
        begin
            drain_all();
            write_reg(CFG_PHI, phi_set[k]);
            write_reg(CFG_COX, cox_set[k]);
            cfg_valid <= 1'b0;
            for (j = 0; j < 128; j++)
            begin
                if (j % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_bias(random_bias(phi_now), 1'b0, '0);
            end
            no_idle = 1'b0;
        end
        drain_all();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
